// File: design/fpap_pkg.sv
// ----------------------------------------------------------------------------
// FTP address argument parser package
// Shared types and character codes for the PORT/PASV argument parser.
// ----------------------------------------------------------------------------
package fpap_pkg;

    // Widths of the result fields.
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned PORT_W  = 16;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned INDEX_W = 3;

    // Field parsing phases.
    localparam logic [1:0] PH_SPACE  = 2'd0;
    localparam logic [1:0] PH_NUMBER = 2'd1;
    localparam logic [1:0] PH_IGNORE = 2'd2;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // Index of the last field.
    localparam logic [INDEX_W-1:0] LAST_FIELD = 3'd5;

    // One parsed result.
    typedef struct packed {
        logic [ADDR_W-1:0] host_address;
        logic [PORT_W-1:0] port_number;
        logic              syntax_error;
    } result_t;

endpackage

// File: design/ftp_port_argument_parser.sv
// ----------------------------------------------------------------------------
// FTP PORT/PASV argument parser
// Reads h1,h2,h3,h4,p1,p2 from a character stream and returns address and port.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one character per beat on char_in; a zero byte
// ends the string. The output channel carries one result beat per string
// (host_address, port_number, syntax_error), issued for the zero byte only.
// A character is taken into an input register and parsed by the field state
// machine when it leaves that register; the result for a zero byte is then
// registered in the output register, from which the receiver takes it.
// Throughput is one character per cycle except while a zero byte waits for the
// output register; the multiply-by-ten accumulate in the field parser is combinational.
// When the receiver stalls, the output register holds its result; ordinary
// characters keep flowing, and a zero byte waits in the input register until
// the output register is free, with the input channel stalled while it waits.
// Reset clears all parsing state and both valid bits; the block is ready as
// soon as reset is released.
// ----------------------------------------------------------------------------
module ftp_port_argument_parser
    import fpap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAR_W-1:0] char_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ADDR_W-1:0] host_address,
    output logic [PORT_W-1:0] port_number,
    output logic              syntax_error
);

    logic              stage_valid;
    logic [CHAR_W-1:0] stage_char;
    logic              advance;
    logic              out_free;
    logic              emit;
    result_t           result;

    // A character moves on unless it is the terminator and the output is full.
    assign advance = stage_valid && ((stage_char != CHAR_NUL) || out_free);

    // Input register.
    fpap_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_in     (char_in),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_char  (stage_char)
    );

    // Field parser.
    fpap_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .stage_char (stage_char),
        .emit       (emit),
        .result     (result)
    );

    // Result register.
    fpap_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (emit),
        .result       (result),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .host_address (host_address),
        .port_number  (port_number),
        .syntax_error (syntax_error)
    );

endmodule

// File: design/fpap_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one character beat and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module fpap_in_stage
    import fpap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAR_W-1:0] char_in,
    input  logic              advance,
    output logic              stage_valid,
    output logic [CHAR_W-1:0] stage_char
);

    logic              valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              hold;

    // The register is held while its beat has not moved on.
    assign hold        = valid_reg && !advance;
    assign in_stall    = hold;
    assign stage_valid = valid_reg;
    assign stage_char  = char_reg;

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            valid_reg <= in_valid;
        end
    end

    // Character payload.
    always_ff @(posedge clk)
    begin
        if (!hold && in_valid)
        begin
            char_reg <= char_in;
        end
    end

endmodule

// File: design/fpap_parse.sv
// ----------------------------------------------------------------------------
// Field parser
// Steps the per-field state machine one character per cycle unless stalled,
// builds the address and port; produces a result on the terminating zero byte.
// ----------------------------------------------------------------------------
module fpap_parse
    import fpap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [CHAR_W-1:0] stage_char,
    output logic              emit,
    output result_t           result
);

    logic [INDEX_W-1:0] field_index_reg, field_index_next;
    logic [1:0]         field_phase_reg, field_phase_next;
    logic               negative_flag_reg, negative_flag_next;
    logic [ADDR_W-1:0]  field_acc_reg, field_acc_next;
    logic [ADDR_W-1:0]  address_build_reg, address_build_next;
    logic [PORT_W-1:0]  port_build_reg, port_build_next;

    logic               is_space;
    logic               is_digit;
    logic [3:0]         digit;
    logic [ADDR_W-1:0]  acc_times_ten;
    logic [ADDR_W-1:0]  field_value;
    logic [ADDR_W-1:0]  address_commit;
    logic [PORT_W-1:0]  port_commit;

    // Character classes.
    assign is_space = (stage_char == CHAR_SPACE) ||
                      ((stage_char >= CHAR_TAB) && (stage_char <= CHAR_CR));
    assign is_digit = (stage_char >= CHAR_ZERO) && (stage_char <= CHAR_NINE);
    assign digit    = stage_char[3:0];

    // Accumulator times ten plus the new digit, modulo 2^32.
    assign acc_times_ten = {field_acc_reg[ADDR_W-4:0], 3'b000}
                         + {field_acc_reg[ADDR_W-2:0], 1'b0}
                         + {{(ADDR_W-4){1'b0}}, digit};

    // Signed field value, negated modulo 2^32.
    assign field_value = negative_flag_reg ? (ADDR_W'(0) - field_acc_reg) : field_acc_reg;

    // Merge the current field into the address or port.
    always_comb
    begin
        address_commit = address_build_reg;
        port_commit    = port_build_reg;
        case (field_index_reg)
            3'd0:    address_commit = address_build_reg | {field_value[7:0], 24'h000000};
            3'd1:    address_commit = address_build_reg | {field_value[15:0], 16'h0000};
            3'd2:    address_commit = address_build_reg | {field_value[23:0], 8'h00};
            3'd3:    address_commit = address_build_reg | field_value;
            3'd4:    port_commit    = port_build_reg | {field_value[7:0], 8'h00};
            3'd5:    port_commit    = port_build_reg | field_value[PORT_W-1:0];
            default: address_commit = address_build_reg;
        endcase
    end

    // Next state and result.
    always_comb
    begin
        field_index_next   = field_index_reg;
        field_phase_next   = field_phase_reg;
        negative_flag_next = negative_flag_reg;
        field_acc_next     = field_acc_reg;
        address_build_next = address_build_reg;
        port_build_next    = port_build_reg;
        emit               = 1'b0;
        result             = '0;

        if (advance)
        begin
            if (stage_char == CHAR_NUL)
            begin
                // End of string: report and return to the reset state.
                emit = 1'b1;
                if (field_index_reg >= LAST_FIELD)
                begin
                    result.host_address = address_commit;
                    result.port_number  = port_commit;
                    result.syntax_error = 1'b0;
                end
                else
                begin
                    result.syntax_error = 1'b1;
                end
                field_index_next   = '0;
                field_phase_next   = PH_SPACE;
                negative_flag_next = 1'b0;
                field_acc_next     = '0;
                address_build_next = '0;
                port_build_next    = '0;
            end
            else if (stage_char == CHAR_COMMA)
            begin
                // A comma closes the field; a comma in the last field ends its number.
                if (field_index_reg < LAST_FIELD)
                begin
                    address_build_next = address_commit;
                    port_build_next    = port_commit;
                    field_index_next   = field_index_reg + 3'd1;
                    field_phase_next   = PH_SPACE;
                    negative_flag_next = 1'b0;
                    field_acc_next     = '0;
                end
                else
                begin
                    field_phase_next = PH_IGNORE;
                end
            end
            else
            begin
                case (field_phase_reg)
                    PH_SPACE:
                    begin
                        if (is_space)
                        begin
                            field_phase_next = PH_SPACE;
                        end
                        else if (stage_char == CHAR_MINUS)
                        begin
                            negative_flag_next = 1'b1;
                            field_phase_next   = PH_NUMBER;
                        end
                        else if (stage_char == CHAR_PLUS)
                        begin
                            field_phase_next = PH_NUMBER;
                        end
                        else if (is_digit)
                        begin
                            field_acc_next   = {{(ADDR_W-4){1'b0}}, digit};
                            field_phase_next = PH_NUMBER;
                        end
                        else
                        begin
                            field_phase_next = PH_IGNORE;
                        end
                    end
                    PH_NUMBER:
                    begin
                        if (is_digit)
                        begin
                            field_acc_next = acc_times_ten;
                        end
                        else
                        begin
                            field_phase_next = PH_IGNORE;
                        end
                    end
                    default:
                    begin
                        field_phase_next = PH_IGNORE;
                    end
                endcase
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg   <= '0;
            field_phase_reg   <= PH_SPACE;
            negative_flag_reg <= 1'b0;
            field_acc_reg     <= '0;
            address_build_reg <= '0;
            port_build_reg    <= '0;
        end
        else
        begin
            field_index_reg   <= field_index_next;
            field_phase_reg   <= field_phase_next;
            negative_flag_reg <= negative_flag_next;
            field_acc_reg     <= field_acc_next;
            address_build_reg <= address_build_next;
            port_build_reg    <= port_build_next;
        end
    end

    // The field counter never passes the last field.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        field_index_reg <= LAST_FIELD)
        else $error("field index beyond last field");

    // After a result the parser is back in its reset state.
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (field_index_reg == '0) && (field_phase_reg == PH_SPACE) &&
                 (address_build_reg == '0) && (port_build_reg == '0))
        else $error("parser state not cleared after result");

    // A syntax error carries a zero address and port.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && result.syntax_error) |->
            (result.host_address == '0) && (result.port_number == '0))
        else $error("syntax error result with nonzero payload");

endmodule

// File: design/fpap_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module fpap_out_stage
    import fpap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  result_t           result,
    output logic              out_free,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ADDR_W-1:0] host_address,
    output logic [PORT_W-1:0] port_number,
    output logic              syntax_error
);

    logic    valid_reg;
    result_t result_reg;

    // The register can take a new result when empty or being drained.
    assign out_free     = !valid_reg || !out_stall;
    assign out_valid    = valid_reg;
    assign host_address = result_reg.host_address;
    assign port_number  = result_reg.port_number;
    assign syntax_error = result_reg.syntax_error;

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= load;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (out_free && load)
        begin
            result_reg <= result;
        end
    end

endmodule

// File: sim/ftp_port_argument_parser_checker.sv
// ----------------------------------------------------------------------------
// FTP PORT/PASV argument parser checker
// Watches both channels, parses each accepted character beat alongside the
// block, and compares every result beat with the oldest parsed endpoint.
// ----------------------------------------------------------------------------
module ftp_port_argument_parser_checker
    import fpap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [CHAR_W-1:0] char_in,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [ADDR_W-1:0] host_address,
    input  logic [PORT_W-1:0] port_number,
    input  logic              syntax_error,
    output int unsigned       mismatch_count,
    output int unsigned       endpoints_pending
);

    // Positions of the six fields in the argument.
    localparam logic [INDEX_W-1:0] FIELD_H1 = 3'd0;
    localparam logic [INDEX_W-1:0] FIELD_H2 = 3'd1;
    localparam logic [INDEX_W-1:0] FIELD_H3 = 3'd2;
    localparam logic [INDEX_W-1:0] FIELD_H4 = 3'd3;
    localparam logic [INDEX_W-1:0] FIELD_P1 = 3'd4;

    // Parser state mirrored from the character stream.
    logic [INDEX_W-1:0] cur_field;
    logic [1:0]         cur_phase;
    logic               cur_negative;
    logic [ADDR_W-1:0]  cur_value;
    logic [ADDR_W-1:0]  addr_bits;
    logic [PORT_W-1:0]  port_bits;

    // Endpoints parsed from accepted strings, oldest first.
    result_t awaited_endpoints[$];

    assign endpoints_pending = awaited_endpoints.size();

    // Start a new field.
    task automatic clear_field();
        cur_phase    = PH_SPACE;
        cur_negative = 1'b0;
        cur_value    = '0;
    endtask

    // Return to the state after reset.
    task automatic clear_parser();
        cur_field = FIELD_H1;
        addr_bits = '0;
        port_bits = '0;
        clear_field();
    endtask

    // Fold the finished field into the address or the port.
    task automatic store_field();
        logic [ADDR_W-1:0] value;
        value = cur_negative ? (32'd0 - cur_value) : cur_value;
        case (cur_field)
            FIELD_H1:   addr_bits |= value << 24;
            FIELD_H2:   addr_bits |= value << 16;
            FIELD_H3:   addr_bits |= value << 8;
            FIELD_H4:   addr_bits |= value;
            FIELD_P1:   port_bits |= {value[7:0], 8'h00};
            LAST_FIELD: port_bits |= value[PORT_W-1:0];
            default: ;
        endcase
    endtask

    // Parse one character; a zero byte queues the endpoint it completes.
    task automatic parse_char(input logic [CHAR_W-1:0] c);
        logic    is_space;
        logic    is_digit;
        result_t endpoint;
        is_space = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        if (c == CHAR_NUL) begin
            if (cur_field >= LAST_FIELD) begin
                store_field();
                endpoint.host_address = addr_bits;
                endpoint.port_number  = port_bits;
                endpoint.syntax_error = 1'b0;
            end
            else begin
                endpoint.host_address = '0;
                endpoint.port_number  = '0;
                endpoint.syntax_error = 1'b1;
            end
            awaited_endpoints.push_back(endpoint);
            clear_parser();
        end
        else if (c == CHAR_COMMA) begin
            // Commas past the fifth only end the last field.
            if (cur_field < LAST_FIELD) begin
                store_field();
                cur_field = cur_field + 3'd1;
                clear_field();
            end
            else begin
                cur_phase = PH_IGNORE;
            end
        end
        else if (cur_phase == PH_SPACE) begin
            if (is_space) begin
                cur_phase = PH_SPACE;
            end
            else if (c == CHAR_MINUS) begin
                cur_negative = 1'b1;
                cur_phase    = PH_NUMBER;
            end
            else if (c == CHAR_PLUS) begin
                cur_phase = PH_NUMBER;
            end
            else if (is_digit) begin
                cur_value = 32'(c - CHAR_ZERO);
                cur_phase = PH_NUMBER;
            end
            else begin
                cur_phase = PH_IGNORE;
            end
        end
        else if (cur_phase == PH_NUMBER) begin
            if (is_digit) begin
                cur_value = cur_value * 32'd10 + 32'(c - CHAR_ZERO);
            end
            else begin
                cur_phase = PH_IGNORE;
            end
        end
        else begin
            cur_phase = PH_IGNORE;
        end
    endtask

    // Track accepted character beats and compare accepted result beats.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n) begin
            clear_parser();
            awaited_endpoints.delete();
            mismatch_count <= 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                parse_char(char_in);
            end
            if (out_valid && !out_stall) begin
                if (awaited_endpoints.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10) begin
                        $display("mismatch: result beat with no string pending: addr %h port %h err %b",
                                 host_address, port_number, syntax_error);
                    end
                end
                else begin
                    want = awaited_endpoints.pop_front();
                    if (host_address !== want.host_address ||
                        port_number !== want.port_number ||
                        syntax_error !== want.syntax_error) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10) begin
                            $display("mismatch: expected addr %h port %h err %b, got addr %h port %h err %b",
                                     want.host_address, want.port_number, want.syntax_error,
                                     host_address, port_number, syntax_error);
                        end
                    end
                end
            end
        end
    end

endmodule

// File: sim/ftp_port_argument_parser_tb.sv
// ----------------------------------------------------------------------------
// FTP PORT/PASV argument parser testbench
// Feeds directed and random argument strings through the parser with random
// idle bursts on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module ftp_port_argument_parser_tb;
    import fpap_pkg::*;

    localparam int unsigned BEAT_TARGET    = 1850;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [CHAR_W-1:0] char_in = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [ADDR_W-1:0] host_address;
    logic [PORT_W-1:0] port_number;
    logic              syntax_error;

    int unsigned mismatch_count;
    int unsigned endpoints_pending;
    int unsigned beats_sent = 0;
    bit          idle_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;

    ftp_port_argument_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_in      (char_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .host_address (host_address),
        .port_number  (port_number),
        .syntax_error (syntax_error)
    );

    ftp_port_argument_parser_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .char_in           (char_in),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .host_address      (host_address),
        .port_number       (port_number),
        .syntax_error      (syntax_error),
        .mismatch_count    (mismatch_count),
        .endpoints_pending (endpoints_pending)
    );

    // Free-running clock.
    always #5 clk = ~clk;

    // Receiver stalls in random bursts while idling is on.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (idle_on && rst_n && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 7) - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Send one character beat and hold it until accepted, then maybe pause.
    task automatic send_beat(input logic [CHAR_W-1:0] c);
        in_valid <= 1'b1;
        char_in  <= c;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        beats_sent = beats_sent + 1;
        // No idling in a middle stretch and in the last part of the run.
        idle_on = (beats_sent < 300 || beats_sent >= 450) && beats_sent < BEAT_TARGET - 250;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            char_in  <= CHAR_W'($urandom);
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_beat(s[i]);
        end
    endtask

    // Any byte but the terminator.
    function automatic logic [CHAR_W-1:0] any_char();
        return CHAR_W'($urandom_range(1, 255));
    endfunction

    // Space or one of the control whitespace bytes.
    function automatic logic [CHAR_W-1:0] blank_char();
        int unsigned pick;
        pick = $urandom_range(0, 5);
        return (pick == 5) ? CHAR_SPACE : CHAR_TAB + CHAR_W'(pick);
    endfunction

    // One argument string of comma-separated fields with random content.
    task automatic send_endpoint(input int unsigned fields);
        int unsigned digits;
        int unsigned sign_pick;
        for (int unsigned f = 0; f < fields; f++)
        begin
            if (f > 0)
            begin
                send_beat(CHAR_COMMA);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 2)) send_beat(blank_char());
            end
            sign_pick = $urandom_range(0, 9);
            if (sign_pick == 0)
            begin
                send_beat(CHAR_MINUS);
            end
            else if (sign_pick == 1)
            begin
                send_beat(CHAR_PLUS);
            end
            // Mostly short numbers, now and then long ones that wrap or none.
            if ($urandom_range(0, 19) == 0)
            begin
                digits = 0;
            end
            else if ($urandom_range(0, 11) == 0)
            begin
                digits = $urandom_range(4, 12);
            end
            else
            begin
                digits = $urandom_range(1, 3);
            end
            repeat (digits) send_beat(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 2)) send_beat(any_char());
            end
        end
        send_beat(CHAR_NUL);
    endtask

    // Stimulus: directed strings, then random ones, then drain.
    initial
    begin : stimulus
        int unsigned kind;
        int unsigned drain_cycles;
        bit          pressure_done;
        pressure_done = 1'b0;
        drain_cycles  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Whitespace, signs, junk after digits, an empty field, a high byte,
        // a wrapping value and commas after the fifth.
        send_text("\t-1,+2a,,");
        send_beat(8'h80);
        send_text("12,9999999999,1,7,8");
        send_beat(CHAR_NUL);
        // Too few commas, with a sign after digits.
        send_text(" 3-4");
        send_beat(CHAR_NUL);
        send_beat(8'hFF);
        send_text(",5");
        send_beat(CHAR_NUL);

        while (beats_sent < BEAT_TARGET)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6 || kind == 9)
            begin
                send_endpoint(($urandom_range(0, 3) == 0) ? $urandom_range(7, 8) : 6);
            end
            else if (kind == 7)
            begin
                send_endpoint($urandom_range(0, 5));
            end
            else
            begin
                repeat ($urandom_range(0, 15)) send_beat(any_char());
                send_beat(CHAR_NUL);
            end
            // Once, hold the sender until every result has come back.
            if (!pressure_done && beats_sent >= BEAT_TARGET / 2)
            begin
                pressure_done = 1'b1;
                in_valid <= 1'b0;
                do @(posedge clk); while (endpoints_pending != 0);
            end
        end

        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            drain_cycles = drain_cycles + 1;
        end while (endpoints_pending != 0 && drain_cycles < 5000);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && endpoints_pending == 0)
        begin
            $display("ftp_port_argument_parser_tb: PASS");
        end
        else
        begin
            $display("ftp_port_argument_parser_tb: FAIL");
        end
        $finish;
    end

    // Watchdog: too many cycles in a row with no beat accepted on either side.
    initial
    begin : watchdog
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles = quiet_cycles + 1;
            end
        end
        $display("ftp_port_argument_parser_tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
design/fpap_pkg.sv
design/fpap_in_stage.sv
design/fpap_parse.sv
design/fpap_out_stage.sv
design/ftp_port_argument_parser.sv
sim/ftp_port_argument_parser_checker.sv
sim/ftp_port_argument_parser_tb.sv
